FILE: src/asn1_oid_arc_decoder_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the object identifier arc decoder
// Concurrent checks, clocked on the rising edge and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ASN1_OID_ARC_DECODER_UNIT_ASSERT_SVH
`define ASN1_OID_ARC_DECODER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASN1OID_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASN1OID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/asn1oid_pkg.sv
// ---------------------------------------------------------------------------
// asn1oid_pkg
// Shared types and constants of the object identifier arc decoder.
// ---------------------------------------------------------------------------
package asn1oid_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 8;
  localparam int CMD_QUEUE_DEPTH     = 4;
  localparam logic [7:0] CAPACITY_RESET = 8'd16;
  localparam logic [4:0] OID_TAG        = 5'd6;
  localparam logic [31:0] ARC_SPLIT     = 32'd40;

  typedef enum logic [2:0] {
    STATUS_OK           = 3'd0,
    STATUS_WRONG_TAG    = 3'd1,
    STATUS_OVERFLOW     = 3'd2,
    STATUS_TRUNCATED    = 3'd3,
    STATUS_BAD_CAPACITY = 3'd4
  } status_t;

  // What the back end has to do with one queued command.
  typedef enum logic [1:0] {
    CMD_ARC   = 2'd0,
    CMD_PAIR  = 2'd1,
    CMD_FINAL = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic [4:0] tag_number;
  } in_item_t;

  typedef struct packed {
    logic [31:0] arc_value;
    logic [7:0]  arc_index;
    logic        arc_valid;
    logic        final_mark;
    status_t     status;
    logic [7:0]  arc_count;
  } result_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] value;
    logic [7:0]  index;
    logic        final_mark;
    status_t     status;
    logic [7:0]  count;
  } cmd_t;

endpackage

FILE: src/asn1oid_front.sv
// ---------------------------------------------------------------------------
// asn1oid_front
// Gathers base-128 subidentifiers, tracks errors and arc counts, and issues
// one command per octet that yields results.
// ---------------------------------------------------------------------------
module asn1oid_front #(
  parameter int COUNT_WIDTH = asn1oid_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  asn1oid_pkg::in_item_t item,
  input  logic [7:0]            capacity,
  output logic                  cmd_push,
  output asn1oid_pkg::cmd_t     cmd
);

  logic [31:0]            accumulator;
  logic [COUNT_WIDTH-1:0] arcs_done;
  asn1oid_pkg::status_t   error_code;
  logic                   tlv_open;

  logic [31:0]            accumulator_next;
  logic [COUNT_WIDTH-1:0] arcs_done_next;
  asn1oid_pkg::status_t   error_code_next;
  logic                   tlv_open_next;
  logic                   have_cmd;

  always_comb begin
    logic [31:0]            acc_w;
    logic [COUNT_WIDTH-1:0] arcs_w;
    asn1oid_pkg::status_t   err_w;
    logic                   open_w;
    logic [31:0]            shifted;

    acc_w  = accumulator;
    arcs_w = arcs_done;
    err_w  = error_code;
    open_w = tlv_open;
    if (item.first_byte) begin
      acc_w  = '0;
      arcs_w = '0;
      open_w = 1'b1;
      if (capacity < 8'd2) begin
        err_w = asn1oid_pkg::STATUS_BAD_CAPACITY;
      end else if (item.tag_number != asn1oid_pkg::OID_TAG) begin
        err_w = asn1oid_pkg::STATUS_WRONG_TAG;
      end else begin
        err_w = asn1oid_pkg::STATUS_OK;
      end
    end

    accumulator_next = acc_w;
    arcs_done_next   = arcs_w;
    error_code_next  = err_w;
    tlv_open_next    = open_w;
    shifted          = {acc_w[24:0], item.data_byte[6:0]};
    have_cmd         = 1'b0;
    cmd.kind         = asn1oid_pkg::CMD_ARC;
    cmd.value        = shifted;
    cmd.index        = 8'(arcs_w);
    cmd.final_mark   = 1'b0;
    cmd.status       = asn1oid_pkg::STATUS_OK;
    cmd.count        = '0;

    if (open_w) begin
      if (err_w == asn1oid_pkg::STATUS_OK) begin
        if (acc_w[31:25] != 7'd0) begin
          error_code_next = asn1oid_pkg::STATUS_OVERFLOW;
        end else if (!item.data_byte[7]) begin
          accumulator_next = '0;
          if (arcs_w == '0) begin
            // The first subidentifier always splits into two arcs.
            have_cmd       = 1'b1;
            cmd.kind       = asn1oid_pkg::CMD_PAIR;
            arcs_done_next = COUNT_WIDTH'(2);
          end else if ((32'(arcs_w) >= 32'(capacity)) || (arcs_w == '1)) begin
            error_code_next = asn1oid_pkg::STATUS_OVERFLOW;
          end else begin
            have_cmd       = 1'b1;
            arcs_done_next = arcs_w + 1'b1;
          end
        end else begin
          accumulator_next = shifted;
          if (item.last_byte) begin
            error_code_next = asn1oid_pkg::STATUS_TRUNCATED;
          end
        end
      end

      if (item.last_byte) begin
        tlv_open_next = 1'b0;
        if (error_code_next != asn1oid_pkg::STATUS_OK) begin
          // An error replaces any arcs of this octet by one status result.
          have_cmd   = 1'b1;
          cmd.kind   = asn1oid_pkg::CMD_FINAL;
          cmd.value  = '0;
          cmd.index  = '0;
          cmd.status = error_code_next;
        end else if (have_cmd) begin
          cmd.count = 8'(arcs_done_next);
        end else begin
          have_cmd  = 1'b1;
          cmd.kind  = asn1oid_pkg::CMD_FINAL;
          cmd.value = '0;
          cmd.index = '0;
          cmd.count = 8'(arcs_done_next);
        end
        cmd.final_mark = 1'b1;
      end
    end
  end

  assign cmd_push = accept && have_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      arcs_done   <= '0;
      error_code  <= asn1oid_pkg::STATUS_OK;
      tlv_open    <= 1'b0;
    end else if (accept) begin
      accumulator <= accumulator_next;
      arcs_done   <= arcs_done_next;
      error_code  <= error_code_next;
      tlv_open    <= tlv_open_next;
    end
  end

endmodule

FILE: src/asn1oid_queue.sv
// ---------------------------------------------------------------------------
// asn1oid_queue
// Short command queue that decouples the front end from the back end.
// ---------------------------------------------------------------------------
`include "asn1_oid_arc_decoder_unit_assert.svh"

module asn1oid_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_en,
  input  asn1oid_pkg::cmd_t push_cmd,
  output logic              full,
  input  logic              pop_en,
  output logic              head_valid,
  output asn1oid_pkg::cmd_t head
);

  localparam int DEPTH = asn1oid_pkg::CMD_QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  asn1oid_pkg::cmd_t entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_pop     = pop_en && head_valid;

  always_ff @(posedge clk) begin
    if (push_en) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push_en && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push_en && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASN1OID_ASSERT_SAME(a_no_push_when_full, clk, rst, push_en, !full,
                       "command pushed into a full queue")
  `ASN1OID_ASSERT_NEXT(a_pop_only_count_drops, clk, rst, do_pop && !push_en && !full,
                       count == $past(count) - 1'b1, "queue count did not fall on a pop")

endmodule

FILE: src/asn1oid_back.sv
// ---------------------------------------------------------------------------
// asn1oid_back
// Turns queued commands into result transactions, splitting the first
// subidentifier into two arcs, and holds the result register.
// ---------------------------------------------------------------------------
`include "asn1_oid_arc_decoder_unit_assert.svh"

module asn1oid_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  asn1oid_pkg::cmd_t    head,
  output logic                 cmd_pop,
  output logic                 out_valid,
  output asn1oid_pkg::result_t out_data,
  input  logic                 out_pop
);

  localparam logic [31:0] SPLIT_TWICE = 2 * asn1oid_pkg::ARC_SPLIT;

  logic                 phase;
  logic                 load;
  logic                 is_pair;
  logic [31:0]          high_arc;
  logic [31:0]          low_arc;
  asn1oid_pkg::result_t res;

  assign is_pair = (head.kind == asn1oid_pkg::CMD_PAIR);
  assign load    = head_valid && (!out_valid || out_pop);
  assign cmd_pop = load && !(is_pair && !phase);

  // min(v / 40, 2) needs only two compares against constants.
  always_comb begin
    if (head.value >= SPLIT_TWICE) begin
      high_arc = 32'd2;
      low_arc  = head.value - SPLIT_TWICE;
    end else if (head.value >= asn1oid_pkg::ARC_SPLIT) begin
      high_arc = 32'd1;
      low_arc  = head.value - asn1oid_pkg::ARC_SPLIT;
    end else begin
      high_arc = 32'd0;
      low_arc  = head.value;
    end
  end

  always_comb begin
    res.arc_value  = head.value;
    res.arc_index  = head.index;
    res.arc_valid  = 1'b1;
    res.final_mark = head.final_mark;
    res.status     = asn1oid_pkg::STATUS_OK;
    res.arc_count  = head.count;
    case (head.kind)
      asn1oid_pkg::CMD_PAIR: begin
        if (!phase) begin
          res.arc_value  = high_arc;
          res.arc_index  = 8'd0;
          res.final_mark = 1'b0;
          res.arc_count  = '0;
        end else begin
          res.arc_value = low_arc;
          res.arc_index = 8'd1;
        end
      end
      asn1oid_pkg::CMD_FINAL: begin
        res.arc_valid = 1'b0;
        res.status    = head.status;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      phase     <= is_pair && !phase;
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res;
    end
  end

  `ASN1OID_ASSERT_SAME(a_second_half_of_pair, clk, rst, phase, head_valid && is_pair,
                       "second arc pending without a pair command at the queue head")
  `ASN1OID_ASSERT_SAME(a_error_has_no_arc, clk, rst,
                       out_valid && (out_data.status != asn1oid_pkg::STATUS_OK),
                       out_data.final_mark && !out_data.arc_valid && (out_data.arc_count == 8'd0),
                       "error status on a result that is not a bare final one")

endmodule

FILE: src/asn1_oid_arc_decoder_unit.sv
// ---------------------------------------------------------------------------
// asn1_oid_arc_decoder_unit
// Decodes the content octets of an object identifier TLV into arcs.
// ---------------------------------------------------------------------------
//
//  Channel   Handshake               Payload
//  -------   ---------------------   ----------------------------------------
//  input     push / full             item   : one content octet and marks
//  result    empty / pop             result : arc or final status and count
//  config    cfg_valid / cfg_ready   cfg_data : arc capacity
//
// The front end updates its accumulator from each accepted octet, so octets
// may follow each other on every clock while full is low.
// Each octet yields at most one queued command; the first subidentifier
// yields two results, which the back end delivers one after the other, so
// the result side sets the pace to one result per cycle while pop is held.
// Reset is synchronous; capacity returns to 16.
// full is raised only when the four-entry command queue fills; results that
// wait at the output do not stop octets from entering until then.
// ---------------------------------------------------------------------------
module asn1_oid_arc_decoder_unit #(
  parameter int COUNT_WIDTH = asn1oid_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  asn1oid_pkg::in_item_t item,
  output logic                 empty,
  input  logic                 pop,
  output asn1oid_pkg::result_t result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_data
);

  // The capacity register must be written by the user only while the block is idle;
  // the block does not enforce this. The front end reads it live for every arc.
  logic [7:0] capacity;

  logic              in_accept;
  logic              cmd_push;
  asn1oid_pkg::cmd_t cmd;
  logic              q_full;
  logic              q_pop;
  logic              head_valid;
  asn1oid_pkg::cmd_t head;
  logic              out_valid;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign in_accept = push && !q_full;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= asn1oid_pkg::CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // Front end: one transaction per cycle while the queue is not full, classifies
  // the octet and updates the accumulator, arc counter and sticky error code.
  asn1oid_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (in_accept),
    .item     (item),
    .capacity (capacity),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  // The queue lets octets keep arriving while the result side is stalled.
  asn1oid_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_en    (cmd_push),
    .push_cmd   (cmd),
    .full       (q_full),
    .pop_en     (q_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back end: expands commands into result transactions behind a register.
  asn1oid_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .cmd_pop    (q_pop),
    .out_valid  (out_valid),
    .out_data   (result),
    .out_pop    (pop)
  );

endmodule
